// ===== src/ptd_pkg.sv =====
`default_nettype none

package ptd_pkg;

  localparam int READY_DEPTH   = 16;
  localparam int BLOCKED_DEPTH = 16;
  localparam int PRIO_LEVELS   = 4;

  localparam int RIDX_W = $clog2(READY_DEPTH);
  localparam int RCNT_W = $clog2(READY_DEPTH + 1);
  localparam int BIDX_W = $clog2(BLOCKED_DEPTH);

  typedef enum logic [1:0] {
    REQ_MAKE_READY = 2'd0,
    REQ_DISPATCH   = 2'd1,
    REQ_BLOCK      = 2'd2,
    REQ_EXIT       = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_READY_FULL   = 2'd1,
    ST_BLOCKED_FULL = 2'd2,
    ST_IDLE         = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_BLK_SCAN,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_POP_RD,
    S_POP_CMP
  } state_e;

  typedef struct packed {
    logic [7:0] tid;
    logic [1:0] prio;
  } entry_t;

  // Circular pointer arithmetic for the ready ring; works for any depth.
  function automatic logic [RIDX_W-1:0] ridx_add(logic [RIDX_W-1:0] base,
                                                 logic [RCNT_W-1:0] offs);
    logic [RCNT_W:0] sum;
    sum = (RCNT_W+1)'(base) + (RCNT_W+1)'(offs);
    if (sum >= (RCNT_W+1)'(READY_DEPTH)) begin
      sum = sum - (RCNT_W+1)'(READY_DEPTH);
    end
    return sum[RIDX_W-1:0];
  endfunction

  function automatic logic [RIDX_W-1:0] ridx_inc(logic [RIDX_W-1:0] idx);
    logic [RIDX_W-1:0] res;
    if (idx == RIDX_W'(READY_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + RIDX_W'(1);
    end
    return res;
  endfunction

  function automatic logic [RIDX_W-1:0] ridx_dec(logic [RIDX_W-1:0] idx);
    logic [RIDX_W-1:0] res;
    if (idx == '0) begin
      res = RIDX_W'(READY_DEPTH - 1);
    end else begin
      res = idx - RIDX_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/priority_thread_dispatcher.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// request   in         start_i / busy_o       req_type_i tid_i prio_i caller_valid_i
//                                             join_pending_i waiter_tid_i
// result    out        done_o (one cycle)     status_o running_valid_o running_tid_o
//                                             switch_needed_o woke_waiter_o
//
// A request transfer needs start_i high and busy_o low at a rising edge. Its result
// shows for one cycle with done_o, while busy_o is already low. The receiver cannot stall.
// From transfer to result: make_ready walks the ready queue from the tail, moving each
// entry of greater priority value, and refuses without a walk when full; dispatch pops
// the head; block scans to the first free slot; exit first searches for a pending waiter, then pops.
// Reset (rst_ni low, asynchronous) empties both tables and makes thread 0 run.

module priority_thread_dispatcher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  tid_i,
  input  wire logic [1:0]  prio_i,
  input  wire logic        caller_valid_i,
  input  wire logic        join_pending_i,
  input  wire logic [7:0]  waiter_tid_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             running_valid_o,
  output logic [7:0]       running_tid_o,
  output logic             switch_needed_o,
  output logic             woke_waiter_o
);
  import ptd_pkg::*;

  state_e              state_q, state_d;

  // Request latched at the transfer.
  req_e                req_q, req_d;
  logic [7:0]          tid_q, tid_d;
  logic [1:0]          prio_q, prio_d;
  logic                caller_q, caller_d;
  logic [7:0]          waiter_q, waiter_d;

  // Ready ring: head pointer and fill count; walk state for the sorted insert.
  logic [RIDX_W-1:0]   head_q, head_d;
  logic [RCNT_W-1:0]   count_q, count_d;
  logic [RIDX_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [RCNT_W-1:0]   remaining_q, remaining_d;
  logic [7:0]          ins_tid_q, ins_tid_d;
  logic [1:0]          ins_prio_q, ins_prio_d;

  // Blocked table occupancy and scan index.
  logic [BLOCKED_DEPTH-1:0] bvalid_q, bvalid_d;
  logic [BIDX_W-1:0]   slot_q, slot_d;

  // Running thread and result fields.
  logic [7:0]          cur_tid_q, cur_tid_d;
  logic                cur_valid_q, cur_valid_d;
  status_e             status_q, status_d;
  logic                sw_q, sw_d;
  logic                woke_q, woke_d;
  logic                done_q, done_d;

  // Memory ports.
  entry_t              rmem [READY_DEPTH];
  logic                rmem_we, rmem_re;
  logic [RIDX_W-1:0]   rmem_waddr, rmem_raddr;
  entry_t              rmem_wdata, rmem_rdata_q;

  entry_t              bmem [BLOCKED_DEPTH];
  logic                bmem_we, bmem_re;
  entry_t              bmem_rdata_q;

  logic [1:0]          prio_cl;
  logic                ready_full;
  logic                slot_last;
  logic                ins_place;
  logic                waiter_hit;

  assign prio_cl    = (int'(prio_i) >= PRIO_LEVELS) ? 2'(PRIO_LEVELS - 1) : prio_i;
  assign ready_full = (count_q == RCNT_W'(READY_DEPTH));
  assign slot_last  = (slot_q == BIDX_W'(BLOCKED_DEPTH - 1));
  assign waiter_hit = (bmem_rdata_q.tid == waiter_q);

  // The new entry lands at wr_ptr once the walk runs out of entries or meets
  // one whose priority value is not greater than its own.
  assign ins_place = ((state_q == S_INS_RD) && (remaining_q == '0)) ||
                     ((state_q == S_INS_CMP) && !(rmem_rdata_q.prio > ins_prio_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_e'(req_type_i))
            REQ_MAKE_READY: state_d = ready_full ? S_IDLE : S_INS_RD;
            REQ_DISPATCH:   state_d = S_POP_RD;
            REQ_BLOCK:      state_d = S_BLK_SCAN;
            REQ_EXIT:       state_d = join_pending_i ? S_SRCH_RD : S_POP_RD;
          endcase
        end
      end
      S_INS_RD, S_INS_CMP: begin
        if (ins_place) begin
          state_d = (req_q == REQ_EXIT) ? S_POP_RD : S_IDLE;
        end else begin
          state_d = (state_q == S_INS_RD) ? S_INS_CMP : S_INS_RD;
        end
      end
      S_BLK_SCAN: begin
        if (!bvalid_q[slot_q] || slot_last) begin
          state_d = S_IDLE;
        end
      end
      S_SRCH_RD: begin
        if (bvalid_q[slot_q]) begin
          state_d = S_SRCH_CMP;
        end else if (slot_last) begin
          state_d = S_POP_RD;
        end
      end
      S_SRCH_CMP: begin
        if (waiter_hit) begin
          state_d = ready_full ? S_POP_RD : S_INS_RD;
        end else begin
          state_d = slot_last ? S_POP_RD : S_SRCH_RD;
        end
      end
      S_POP_RD:  state_d = (count_q == '0) ? S_IDLE : S_POP_CMP;
      S_POP_CMP: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and result updates.
  always_comb begin
    req_d       = req_q;
    tid_d       = tid_q;
    prio_d      = prio_q;
    caller_d    = caller_q;
    waiter_d    = waiter_q;
    head_d      = head_q;
    count_d     = count_q;
    wr_ptr_d    = wr_ptr_q;
    remaining_d = remaining_q;
    ins_tid_d   = ins_tid_q;
    ins_prio_d  = ins_prio_q;
    bvalid_d    = bvalid_q;
    slot_d      = slot_q;
    cur_tid_d   = cur_tid_q;
    cur_valid_d = cur_valid_q;
    status_d    = status_q;
    sw_d        = sw_q;
    woke_d      = woke_q;
    done_d      = 1'b0;

    rmem_we     = 1'b0;
    rmem_re     = 1'b0;
    rmem_waddr  = wr_ptr_q;
    rmem_raddr  = ridx_dec(wr_ptr_q);
    rmem_wdata  = '{tid: ins_tid_q, prio: ins_prio_q};
    bmem_we     = 1'b0;
    bmem_re     = 1'b0;

    if (ins_place) begin
      rmem_we = 1'b1;
      count_d = count_q + RCNT_W'(1);
      if (req_q == REQ_EXIT) begin
        woke_d           = 1'b1;
        bvalid_d[slot_q] = 1'b0;
      end else begin
        done_d = 1'b1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d       = req_e'(req_type_i);
          tid_d       = tid_i;
          prio_d      = prio_cl;
          caller_d    = caller_valid_i;
          waiter_d    = waiter_tid_i;
          ins_tid_d   = tid_i;
          ins_prio_d  = prio_cl;
          wr_ptr_d    = ridx_add(head_q, count_q);
          remaining_d = count_q;
          slot_d      = '0;
          status_d    = ST_OK;
          sw_d        = 1'b0;
          woke_d      = 1'b0;
          unique case (req_e'(req_type_i))
            REQ_MAKE_READY: begin
              if (ready_full) begin
                status_d = ST_READY_FULL;
                done_d   = 1'b1;
              end
            end
            REQ_EXIT: begin
              cur_valid_d = 1'b0;
              cur_tid_d   = '0;
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        if (remaining_q != '0) begin
          rmem_re = 1'b1;
        end
      end
      S_INS_CMP: begin
        if (!ins_place) begin
          // Shift the greater entry one place toward the tail.
          rmem_we     = 1'b1;
          rmem_wdata  = rmem_rdata_q;
          wr_ptr_d    = ridx_dec(wr_ptr_q);
          remaining_d = remaining_q - RCNT_W'(1);
        end
      end
      S_BLK_SCAN: begin
        if (!bvalid_q[slot_q]) begin
          bmem_we          = 1'b1;
          bvalid_d[slot_q] = 1'b1;
          done_d           = 1'b1;
        end else if (slot_last) begin
          status_d = ST_BLOCKED_FULL;
          done_d   = 1'b1;
        end else begin
          slot_d = slot_q + BIDX_W'(1);
        end
      end
      S_SRCH_RD: begin
        if (bvalid_q[slot_q]) begin
          bmem_re = 1'b1;
        end else if (!slot_last) begin
          slot_d = slot_q + BIDX_W'(1);
        end
      end
      S_SRCH_CMP: begin
        if (waiter_hit) begin
          if (ready_full) begin
            status_d = ST_READY_FULL;
          end else begin
            ins_tid_d   = bmem_rdata_q.tid;
            ins_prio_d  = bmem_rdata_q.prio;
            wr_ptr_d    = ridx_add(head_q, count_q);
            remaining_d = count_q;
          end
        end else if (!slot_last) begin
          slot_d = slot_q + BIDX_W'(1);
        end
      end
      S_POP_RD: begin
        if (count_q == '0) begin
          status_d = ST_IDLE;
          done_d   = 1'b1;
        end else begin
          rmem_re    = 1'b1;
          rmem_raddr = head_q;
        end
      end
      S_POP_CMP: begin
        cur_tid_d   = rmem_rdata_q.tid;
        cur_valid_d = 1'b1;
        head_d      = ridx_inc(head_q);
        count_d     = count_q - RCNT_W'(1);
        // An exit dispatch has no caller, so any dispatched thread is a switch.
        sw_d        = (req_q == REQ_EXIT) ? 1'b1
                                          : !(caller_q && (rmem_rdata_q.tid == tid_q));
        done_d      = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state and results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      bvalid_q    <= '0;
      cur_tid_q   <= '0;
      cur_valid_q <= 1'b1;
      status_q    <= ST_OK;
      sw_q        <= 1'b0;
      woke_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      bvalid_q    <= bvalid_d;
      cur_tid_q   <= cur_tid_d;
      cur_valid_q <= cur_valid_d;
      status_q    <= status_d;
      sw_q        <= sw_d;
      woke_q      <= woke_d;
      done_q      <= done_d;
    end
  end

  // Request payload and walk registers.
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    tid_q       <= tid_d;
    prio_q      <= prio_d;
    caller_q    <= caller_d;
    waiter_q    <= waiter_d;
    wr_ptr_q    <= wr_ptr_d;
    remaining_q <= remaining_d;
    ins_tid_q   <= ins_tid_d;
    ins_prio_q  <= ins_prio_d;
    slot_q      <= slot_d;
  end

  // Ready ring memory.
  always_ff @(posedge clk_i) begin
    if (rmem_we) begin
      rmem[rmem_waddr] <= rmem_wdata;
    end
    if (rmem_re) begin
      rmem_rdata_q <= rmem[rmem_raddr];
    end
  end

  // Blocked table memory.
  always_ff @(posedge clk_i) begin
    if (bmem_we) begin
      bmem[slot_q] <= '{tid: tid_q, prio: prio_q};
    end
    if (bmem_re) begin
      bmem_rdata_q <= bmem[slot_q];
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign running_valid_o = cur_valid_q;
  assign running_tid_o   = cur_valid_q ? cur_tid_q : 8'd0;
  assign switch_needed_o = sw_q;
  assign woke_waiter_o   = woke_q;

endmodule

`default_nettype wire

// ===== test/ptd_checker.sv =====
`timescale 1ns / 100ps

module ptd_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  tid_i,
  input  wire logic [1:0]  prio_i,
  input  wire logic        caller_valid_i,
  input  wire logic        join_pending_i,
  input  wire logic [7:0]  waiter_tid_i,
  input  wire logic        done_i,
  input  wire logic [1:0]  status_i,
  input  wire logic        running_valid_i,
  input  wire logic [7:0]  running_tid_i,
  input  wire logic        switch_needed_i,
  input  wire logic        woke_waiter_i,
  output int               errors_o,
  output int               pending_o,
  output int               compared_o,
  output int               wakes_o,
  output int               refusals_o,
  output int               idles_o
);

  import ptd_pkg::*;

  typedef struct {
    status_e    status;
    logic       running_valid;
    logic [7:0] running_tid;
    logic       switch_needed;
    logic       woke_waiter;
  } outcome_t;

  // Shadow copy of the dispatcher state.
  entry_t     ready_q[$];
  entry_t     parked[BLOCKED_DEPTH];
  logic       parked_used[BLOCKED_DEPTH];
  logic [7:0] run_tid;
  logic       run_valid;

  outcome_t   outcome_q[$];
  int         mismatches;
  int         compared;
  int         wakes;
  int         refusals;
  int         idles;

  function automatic logic [1:0] sat_prio(input logic [1:0] p);
    if (int'(p) >= PRIO_LEVELS) begin
      return 2'(PRIO_LEVELS - 1);
    end
    return p;
  endfunction

  // Sorted insert: the new entry goes ahead of the first strictly lower-priority one.
  task automatic ready_push(input entry_t e, output logic ok);
    int at;
    ok = 1'b0;
    if (ready_q.size() < READY_DEPTH) begin
      at = ready_q.size();
      for (int i = ready_q.size() - 1; i >= 0; i--) begin
        if (e.prio < ready_q[i].prio) begin
          at = i;
        end
      end
      ready_q.insert(at, e);
      ok = 1'b1;
    end
  endtask

  task automatic ready_take(output logic ok, output logic [7:0] picked);
    entry_t head;
    ok = 1'b0;
    picked = '0;
    if (ready_q.size() != 0) begin
      head = ready_q.pop_front();
      picked = head.tid;
      run_tid = head.tid;
      run_valid = 1'b1;
      ok = 1'b1;
    end
  endtask

  task automatic schedule(input req_e req, input logic [7:0] tid, input logic [1:0] prio,
                          input logic caller_v, input logic join_p,
                          input logic [7:0] waiter, output outcome_t res);
    entry_t     e;
    logic       ok;
    logic [7:0] picked;
    int         slot;
    res.status = ST_OK;
    res.switch_needed = 1'b0;
    res.woke_waiter = 1'b0;
    e.tid = tid;
    e.prio = sat_prio(prio);
    case (req)
      REQ_MAKE_READY: begin
        ready_push(e, ok);
        if (!ok) begin
          res.status = ST_READY_FULL;
        end
      end
      REQ_DISPATCH: begin
        ready_take(ok, picked);
        if (ok) begin
          res.switch_needed = !(caller_v && picked == tid);
        end else begin
          res.status = ST_IDLE;
        end
      end
      REQ_BLOCK: begin
        slot = -1;
        for (int i = 0; i < BLOCKED_DEPTH; i++) begin
          if (slot < 0 && !parked_used[i]) begin
            slot = i;
          end
        end
        if (slot >= 0) begin
          parked_used[slot] = 1'b1;
          parked[slot] = e;
        end else begin
          res.status = ST_BLOCKED_FULL;
        end
      end
      default: begin
        run_valid = 1'b0;
        run_tid = '0;
        if (join_p) begin
          slot = -1;
          for (int i = 0; i < BLOCKED_DEPTH; i++) begin
            if (slot < 0 && parked_used[i] && parked[i].tid == waiter) begin
              slot = i;
            end
          end
          if (slot >= 0) begin
            ready_push(parked[slot], ok);
            if (ok) begin
              parked_used[slot] = 1'b0;
              res.woke_waiter = 1'b1;
            end else begin
              res.status = ST_READY_FULL;
            end
          end
        end
        ready_take(ok, picked);
        if (ok) begin
          res.switch_needed = 1'b1;
        end else begin
          res.status = ST_IDLE;
        end
      end
    endcase
    res.running_valid = run_valid;
    res.running_tid = run_valid ? run_tid : 8'd0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    outcome_t want;
    logic     bad;
    if (!rst_ni) begin
      ready_q.delete();
      outcome_q.delete();
      for (int i = 0; i < BLOCKED_DEPTH; i++) begin
        parked_used[i] = 1'b0;
      end
      run_tid = '0;
      run_valid = 1'b1;
      mismatches = 0;
      compared = 0;
      wakes = 0;
      refusals = 0;
      idles = 0;
    end else begin
      // The result of an earlier transfer is checked before a new transfer is predicted.
      if (done_i) begin
        got.status = status_e'(status_i);
        got.running_valid = running_valid_i;
        got.running_tid = running_tid_i;
        got.switch_needed = switch_needed_i;
        got.woke_waiter = woke_waiter_i;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no request outstanding: status=%0d run=%0d/%0d",
                     $time, got.status, got.running_valid, got.running_tid);
          end
        end else begin
          want = outcome_q.pop_front();
          compared++;
          bad = (got.status !== want.status) ||
                (got.running_valid !== want.running_valid) ||
                (got.running_tid !== want.running_tid) ||
                (got.switch_needed !== want.switch_needed) ||
                (got.woke_waiter !== want.woke_waiter);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected status=%0d run=%0d/%0d sw=%0d woke=%0d",
                       $time, want.status, want.running_valid, want.running_tid,
                       want.switch_needed, want.woke_waiter);
              $display("%0t:           actual   status=%0d run=%0d/%0d sw=%0d woke=%0d",
                       $time, got.status, got.running_valid, got.running_tid,
                       got.switch_needed, got.woke_waiter);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        schedule(req_e'(req_type_i), tid_i, prio_i, caller_valid_i, join_pending_i,
                 waiter_tid_i, want);
        if (want.woke_waiter) begin
          wakes++;
        end
        if (want.status == ST_READY_FULL || want.status == ST_BLOCKED_FULL) begin
          refusals++;
        end
        if (want.status == ST_IDLE) begin
          idles++;
        end
        outcome_q.push_back(want);
      end
    end
    errors_o <= mismatches;
    pending_o <= outcome_q.size();
    compared_o <= compared;
    wakes_o <= wakes;
    refusals_o <= refusals;
    idles_o <= idles;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  import ptd_pkg::*;

  // Random requests after the directed opening.
  localparam int N_RANDOM     = 1450;
  // Items in one traffic phase; the phase picks the request mix.
  localparam int PHASE_LEN    = 100;
  // Longest request is an exit that searches the whole blocked table, walks the
  // full ready queue and pops; this many cycles covers it with margin.
  localparam int DRAIN_CYCLES = 80;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] req_type;
  logic [7:0] tid;
  logic [1:0] prio;
  logic       caller_valid;
  logic       join_pending;
  logic [7:0] waiter_tid;
  logic       done;
  logic [1:0] status;
  logic       running_valid;
  logic [7:0] running_tid;
  logic       switch_needed;
  logic       woke_waiter;

  int errors;
  int pending;
  int compared;
  int wakes;
  int refusals;
  int idles;
  int issued;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  priority_thread_dispatcher dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_o          (busy),
    .req_type_i      (req_type),
    .tid_i           (tid),
    .prio_i          (prio),
    .caller_valid_i  (caller_valid),
    .join_pending_i  (join_pending),
    .waiter_tid_i    (waiter_tid),
    .done_o          (done),
    .status_o        (status),
    .running_valid_o (running_valid),
    .running_tid_o   (running_tid),
    .switch_needed_o (switch_needed),
    .woke_waiter_o   (woke_waiter)
  );

  // The checker sits beside the block, watches both channels and keeps the
  // shadow scheduler; this module only drives requests and decides the verdict.
  ptd_checker chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .req_type_i      (req_type),
    .tid_i           (tid),
    .prio_i          (prio),
    .caller_valid_i  (caller_valid),
    .join_pending_i  (join_pending),
    .waiter_tid_i    (waiter_tid),
    .done_i          (done),
    .status_i        (status),
    .running_valid_i (running_valid),
    .running_tid_i   (running_tid),
    .switch_needed_i (switch_needed),
    .woke_waiter_i   (woke_waiter),
    .errors_o        (errors),
    .pending_o       (pending),
    .compared_o      (compared),
    .wakes_o         (wakes),
    .refusals_o      (refusals),
    .idles_o         (idles)
  );

  // Presents one request and holds it until the transfer takes place. The caller
  // is always at a rising edge, so every drive below is a single nonblocking
  // update in that time step. When idling is allowed, the sender then pauses
  // in about 38 of 100 cases: mostly a short gap, sometimes one long enough
  // to run past the end of the request in flight, and junk sits on the fields.
  task automatic issue(input req_e req, input logic [7:0] t, input logic [1:0] p,
                       input logic cv, input logic jp, input logic [7:0] w,
                       input bit may_idle);
    int gap;
    start <= 1'b1;
    req_type <= req;
    tid <= t;
    prio <= p;
    caller_valid <= cv;
    join_pending <= jp;
    waiter_tid <= w;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    issued++;
    if (may_idle && $urandom_range(0, 99) < 38) begin
      gap = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      start <= 1'b0;
      req_type <= 2'($urandom);
      tid <= 8'($urandom);
      prio <= 2'($urandom);
      caller_valid <= 1'($urandom);
      join_pending <= 1'($urandom);
      waiter_tid <= 8'($urandom);
      repeat (gap) begin
        @(posedge clk);
      end
    end
  endtask

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int         mode;
    int         roll;
    int         cut_ready;
    int         cut_dispatch;
    int         cut_block;
    bit         pool;
    req_e       kind;
    logic [7:0] t;
    logic [7:0] w;

    issued = 0;
    rst_n = 1'b0;
    start = 1'b0;
    req_type = REQ_MAKE_READY;
    tid = '0;
    prio = '0;
    caller_valid = 1'b0;
    join_pending = 1'b0;
    waiter_tid = '0;
    repeat (10) begin
      @(posedge clk);
    end
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. Dispatch on an empty queue leaves the main thread running.
    issue(REQ_DISPATCH, 8'd0, 2'd0, 1'b1, 1'b0, 8'd0, 1'b1);
    // Priority extremes, FIFO order among equals, both tid extremes.
    issue(REQ_MAKE_READY, 8'd255, 2'd3, 1'b0, 1'b0, 8'd0, 1'b1);
    issue(REQ_MAKE_READY, 8'd0, 2'd0, 1'b1, 1'b1, 8'd255, 1'b1);
    issue(REQ_MAKE_READY, 8'd10, 2'd3, 1'b0, 1'b0, 8'd0, 1'b1);
    issue(REQ_MAKE_READY, 8'd11, 2'd0, 1'b0, 1'b0, 8'd0, 1'b1);
    issue(REQ_MAKE_READY, 8'd12, 2'd2, 1'b0, 1'b0, 8'd0, 1'b1);
    // The caller gets its own thread back: no switch.
    issue(REQ_DISPATCH, 8'd0, 2'd0, 1'b1, 1'b0, 8'd0, 1'b1);
    // Caller not live, then a live caller that differs: both switch.
    issue(REQ_DISPATCH, 8'd11, 2'd0, 1'b0, 1'b0, 8'd0, 1'b1);
    issue(REQ_DISPATCH, 8'd99, 2'd1, 1'b1, 1'b0, 8'd0, 1'b1);
    // Blocked threads, including a duplicate tid in a later slot.
    issue(REQ_BLOCK, 8'd200, 2'd1, 1'b0, 1'b0, 8'd0, 1'b1);
    issue(REQ_BLOCK, 8'd201, 2'd0, 1'b0, 1'b0, 8'd0, 1'b1);
    issue(REQ_BLOCK, 8'd200, 2'd2, 1'b0, 1'b0, 8'd0, 1'b1);
    // Exit that wakes the lowest duplicate, which then jumps ahead of priority 3.
    issue(REQ_EXIT, 8'd0, 2'd0, 1'b0, 1'b1, 8'd200, 1'b1);
    // Exit without a join, with a waiter that is not blocked, and one that wakes tid 201.
    issue(REQ_EXIT, 8'd0, 2'd0, 1'b0, 1'b0, 8'd201, 1'b1);
    issue(REQ_EXIT, 8'd255, 2'd3, 1'b1, 1'b1, 8'd77, 1'b1);
    issue(REQ_EXIT, 8'd0, 2'd0, 1'b0, 1'b1, 8'd201, 1'b1);
    // Exit with an empty queue leaves nothing running; exit again with no
    // running thread still wakes the remaining duplicate and runs it.
    issue(REQ_EXIT, 8'd0, 2'd0, 1'b0, 1'b0, 8'd0, 1'b1);
    issue(REQ_EXIT, 8'd0, 2'd0, 1'b0, 1'b1, 8'd200, 1'b1);
    issue(REQ_EXIT, 8'd0, 2'd0, 1'b0, 1'b0, 8'd0, 1'b1);
    issue(REQ_DISPATCH, 8'd0, 2'd0, 1'b1, 1'b0, 8'd0, 1'b1);
    issue(REQ_MAKE_READY, 8'h55, 2'd1, 1'b0, 1'b0, 8'hAA, 1'b1);
    issue(REQ_DISPATCH, 8'hAA, 2'd2, 1'b0, 1'b1, 8'h55, 1'b1);

    // Random traffic in phases that cycle through request mixes: balanced,
    // filling the ready queue, filling the blocked table, draining, and joins.
    // The filling phases push the tables into their full cases, and the small
    // tid pool makes join searches and caller matches hit often. Items 500 to
    // 749 are sent back to back with no idling.
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = (n / PHASE_LEN) % 5;
      case (mode)
        0: begin cut_ready = 30; cut_dispatch = 55; cut_block = 75; end
        1: begin cut_ready = 70; cut_dispatch = 78; cut_block = 90; end
        2: begin cut_ready = 20; cut_dispatch = 30; cut_block = 85; end
        3: begin cut_ready = 10; cut_dispatch = 55; cut_block = 65; end
        default: begin cut_ready = 35; cut_dispatch = 50; cut_block = 70; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < cut_ready) begin
        kind = REQ_MAKE_READY;
      end else if (roll < cut_dispatch) begin
        kind = REQ_DISPATCH;
      end else if (roll < cut_block) begin
        kind = REQ_BLOCK;
      end else begin
        kind = REQ_EXIT;
      end
      pool = (mode == 2) || (mode == 4) || ($urandom_range(0, 1) == 1);
      t = pool ? 8'($urandom_range(0, 7)) : 8'($urandom);
      w = pool ? 8'($urandom_range(0, 7)) : 8'($urandom);
      issue(kind, t, 2'($urandom), $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 75,
            w, !(n >= 500 && n < 750));
    end
    start <= 1'b0;

    // One edge first so the checker's count includes the last transfer.
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) begin
      @(posedge clk);
    end

    $display("Covered %0d requests of all four kinds; %0d results compared.", issued, compared);
    $display("Seen: %0d join wakeups, %0d full-table refusals, %0d idle dispatches.",
             wakes, refusals, idles);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== priority_thread_dispatcher.f =====
src/ptd_pkg.sv
src/priority_thread_dispatcher.sv
test/ptd_checker.sv
test/testbench.sv
